>>> sv/cdtpf_pkg.sv
package cdtpf_pkg;

   localparam int PACK_DATA_LEN = 12;
   localparam int PACK_LEN      = 18;

   localparam logic [15:0] CRC_POLY     = 16'h1021;
   localparam logic [7:0]  PACK_TYPE_HI = 8'h80;
   localparam logic [3:0]  CHAR_POS_MAX = 4'hf;
   localparam logic [3:0]  TYPE_GENRE   = 4'd7;
   localparam logic [3:0]  TYPE_TOC1    = 4'd8;

   // x / 3 == (x * DIV3_RECIP) >> DIV3_SHIFT for x below 2**17
   localparam logic [15:0] DIV3_RECIP = 16'haaab;
   localparam int          DIV3_SHIFT = 17;

   typedef enum logic [1:0] {
      CMD_DATA     = 2'd0,
      CMD_FLUSH    = 2'd1,
      CMD_LOAD_SEQ = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic [3:0] pack_type;
      logic [6:0] track_number;
      logic [2:0] block_number;
      logic       binary_item;
      logic       item_start;
      logic       item_end;
   } req_type;

   typedef struct packed {
      logic [7:0] pack_byte;
      logic [4:0] byte_index;
      logic       pack_last;
   } rsp_type;

   // header and fill of the held pack, as seen by the serializer
   typedef struct packed {
      logic [3:0] pack_type;
      logic [7:0] track;
      logic [7:0] sequence_num;
      logic [6:0] block_char;
      logic [3:0] fill;
   } hdr_type;

   typedef struct packed {
      logic       done;
      logic       rd_en;
      logic [3:0] rd_addr;
   } ser_status_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> sv/cdtpf_pack_serializer.sv
module cdtpf_pack_serializer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    run,
   input  cdtpf_pkg::hdr_type      hdr,
   input  logic [7:0]              rd_data,
   output cdtpf_pkg::ser_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cdtpf_pkg::rsp_type      rsp_data
);
   import cdtpf_pkg::*;

   localparam logic [4:0] IdxTrack = 5'd1;
   localparam logic [4:0] IdxSeq   = 5'd2;
   localparam logic [4:0] IdxBlock = 5'd3;
   localparam logic [4:0] IdxData  = 5'd4;
   localparam logic [4:0] IdxCrcHi = 5'd16;
   localparam logic [4:0] IdxLast  = 5'(PACK_LEN - 1);

   logic [4:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic       out_free;
   logic       load;
   logic       last;
   logic [3:0] didx;
   logic [4:0] rd_idx;
   logic [7:0] byte_cur;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = run && out_free;
   assign last     = (idx_ff == IdxLast);
   assign didx     = idx_ff[3:0] - 4'd4;

   always_comb begin
      if (idx_ff == 5'd0) begin
         byte_cur = PACK_TYPE_HI | {4'b0000, hdr.pack_type};
      end else if (idx_ff == IdxTrack) begin
         byte_cur = hdr.track;
      end else if (idx_ff == IdxSeq) begin
         byte_cur = hdr.sequence_num;
      end else if (idx_ff == IdxBlock) begin
         byte_cur = {1'b0, hdr.block_char};
      end else if (idx_ff == IdxCrcHi) begin
         byte_cur = ~crc_ff[15:8];
      end else if (idx_ff == IdxLast) begin
         byte_cur = ~crc_ff[7:0];
      end else begin
         byte_cur = (didx < hdr.fill) ? rd_data : 8'h00;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      if (load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.pack_byte  = byte_cur;
         rsp_data_in.byte_index = idx_ff;
         rsp_data_in.pack_last  = last;
         if (last) begin
            idx_in = 5'd0;
            crc_in = 16'h0000;
         end else begin
            idx_in = idx_ff + 5'd1;
            if (idx_ff < IdxCrcHi) begin
               crc_in = crc16_byte(crc_ff, byte_cur);
            end
         end
      end
   end

   // buffer address for the byte that is current next cycle
   assign rd_idx         = idx_in - IdxData;
   assign status.rd_en   = (idx_in >= IdxData) && (idx_in < IdxCrcHi);
   assign status.rd_addr = rd_idx[3:0];
   assign status.done    = load && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 5'd0;
         crc_ff       <= 16'h0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/cd_text_pack_framer.sv
// CD-TEXT pack framer.
// Input channel req_*: one transaction per command. A data command carries one
// item byte with its pack type, track, block and item flags; flush emits the
// held partial pack; load sets the pack sequence counter.
// Result channel rsp_*: one transaction per pack byte, 18 per pack, header
// first and inverted CRC-16 last, with pack_last on the final byte.
// Steps: a data byte passes the decide and write states, and the create state
// as well when it opens a new pack. A byte that forces out the held pack waits
// for that pack to be emitted; a byte that fills a pack, or ends a binary item,
// is followed by the emission of its pack. The pack bytes are read back one per
// cycle, unless rsp_stall holds them, from the 12-entry data buffer.
// req_stall is high whenever a transaction is still being processed.
// A stall on rsp_stall holds the output byte and freezes serialization;
// the next input transaction waits until the pack is out.
// Reset clears the held pack, the sequence counter and the item position;
// no clearing of the buffer is needed since unfilled bytes read as zero.
module cd_text_pack_framer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cdtpf_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cdtpf_pkg::rsp_type rsp_data
);
   import cdtpf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_EMIT,
      ST_CREATE,
      ST_WRITE
   } state_type;

   localparam logic [3:0] LastFill = 4'(PACK_DATA_LEN - 1);

   state_type   state_ff, state_in;
   req_type     item_ff, item_in;
   logic        pack_held_ff, pack_held_in;
   logic        held_binary_ff, held_binary_in;
   logic [3:0]  held_type_ff, held_type_in;
   logic [7:0]  held_track_ff, held_track_in;
   logic [7:0]  held_seq_ff, held_seq_in;
   logic [6:0]  held_bc_ff, held_bc_in;
   logic [7:0]  seq_cnt_ff, seq_cnt_in;
   logic [15:0] item_pos_ff, item_pos_in;
   logic [3:0]  fill_ff, fill_in;
   logic        create_after_ff, create_after_in;

   logic [7:0] buf_mem [PACK_DATA_LEN];
   logic [7:0] rd_ff;
   logic       wr_en;

   hdr_type        hdr;
   ser_status_type ser_status;

   logic        new_needed;
   logic [29:0] prod;
   logic [12:0] pos;
   logic [12:0] pos_m1;
   logic [7:0]  bin_track;
   logic [3:0]  bin_cp;
   logic [3:0]  text_cp;

   // item_position / 12 as (item_position >> 2) / 3
   assign prod   = {16'b0, item_pos_ff[15:2]} * {14'b0, DIV3_RECIP};
   assign pos    = prod[29:DIV3_SHIFT];
   assign pos_m1 = pos - 13'd1;

   always_comb begin
      bin_cp    = 4'd0;
      bin_track = pos[7:0];
      if (item_ff.pack_type == TYPE_GENRE) begin
         bin_track = 8'h00;
         if (pos == 13'd1) begin
            bin_cp = 4'd10;
         end else if (pos != 13'd0) begin
            bin_cp = CHAR_POS_MAX;
         end
      end else if (item_ff.pack_type == TYPE_TOC1) begin
         bin_track = (pos == 13'd0) ? 8'h00 : {pos_m1[5:0], 2'b01};
      end
   end

   assign text_cp = (item_pos_ff > 16'(CHAR_POS_MAX)) ? CHAR_POS_MAX : item_pos_ff[3:0];

   always_comb begin
      if (item_ff.binary_item) begin
         new_needed = item_ff.item_start || !pack_held_ff || !held_binary_ff;
      end else begin
         new_needed = !(pack_held_ff && !held_binary_ff &&
                        (!item_ff.item_start ||
                         (held_type_ff == item_ff.pack_type &&
                          held_bc_ff[6:4] == item_ff.block_number)));
      end
   end

   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      pack_held_in    = pack_held_ff;
      held_binary_in  = held_binary_ff;
      held_type_in    = held_type_ff;
      held_track_in   = held_track_ff;
      held_seq_in     = held_seq_ff;
      held_bc_in      = held_bc_ff;
      seq_cnt_in      = seq_cnt_ff;
      item_pos_in     = item_pos_ff;
      fill_in         = fill_ff;
      create_after_in = create_after_ff;
      wr_en           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            unique case (item_ff.cmd)
               CMD_FLUSH: begin
                  create_after_in = 1'b0;
                  state_in        = pack_held_ff ? ST_EMIT : ST_IDLE;
               end
               CMD_LOAD_SEQ: begin
                  seq_cnt_in = item_ff.data_byte;
                  state_in   = ST_IDLE;
               end
               CMD_DATA: begin
                  if (item_ff.item_start) begin
                     item_pos_in = 16'h0000;
                  end
                  create_after_in = 1'b1;
                  if (!new_needed) begin
                     state_in = ST_WRITE;
                  end else if (pack_held_ff) begin
                     state_in = ST_EMIT;
                  end else begin
                     state_in = ST_CREATE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT: begin
            if (ser_status.done) begin
               pack_held_in = 1'b0;
               fill_in      = 4'd0;
               state_in     = create_after_ff ? ST_CREATE : ST_IDLE;
            end
         end
         ST_CREATE: begin
            pack_held_in   = 1'b1;
            held_binary_in = item_ff.binary_item;
            held_type_in   = item_ff.pack_type;
            held_seq_in    = seq_cnt_ff;
            seq_cnt_in     = seq_cnt_ff + 8'd1;
            fill_in        = 4'd0;
            if (item_ff.binary_item) begin
               held_track_in = bin_track;
               held_bc_in    = {item_ff.block_number, bin_cp};
            end else begin
               held_track_in = {1'b0, item_ff.track_number};
               held_bc_in    = {item_ff.block_number, text_cp};
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            wr_en   = 1'b1;
            fill_in = fill_ff + 4'd1;
            if (item_pos_ff != 16'hffff) begin
               item_pos_in = item_pos_ff + 16'd1;
            end
            create_after_in = 1'b0;
            if (fill_ff == LastFill || (item_ff.binary_item && item_ff.item_end)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pack_held_ff    <= 1'b0;
         held_binary_ff  <= 1'b0;
         held_type_ff    <= 4'd0;
         held_track_ff   <= 8'h00;
         held_seq_ff     <= 8'h00;
         held_bc_ff      <= 7'h00;
         seq_cnt_ff      <= 8'h00;
         item_pos_ff     <= 16'h0000;
         fill_ff         <= 4'd0;
         create_after_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pack_held_ff    <= pack_held_in;
         held_binary_ff  <= held_binary_in;
         held_type_ff    <= held_type_in;
         held_track_ff   <= held_track_in;
         held_seq_ff     <= held_seq_in;
         held_bc_ff      <= held_bc_in;
         seq_cnt_ff      <= seq_cnt_in;
         item_pos_ff     <= item_pos_in;
         fill_ff         <= fill_in;
         create_after_ff <= create_after_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // pack data buffer, bytes past the fill count read as zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[fill_ff] <= item_ff.data_byte;
      end
      if (ser_status.rd_en) begin
         rd_ff <= buf_mem[ser_status.rd_addr];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   assign hdr.pack_type    = held_type_ff;
   assign hdr.track        = held_track_ff;
   assign hdr.sequence_num = held_seq_ff;
   assign hdr.block_char   = held_bc_ff;
   assign hdr.fill         = fill_ff;

   cdtpf_pack_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .run       (state_ff == ST_EMIT),
      .hdr       (hdr),
      .rd_data   (rd_ff),
      .status    (ser_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_emit_has_pack: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> pack_held_ff)
      else $error("emitting with no pack held");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> pack_held_ff && fill_ff < 4'(PACK_DATA_LEN))
      else $error("buffer write outside a held pack");

   a_done_releases: assert property (@(posedge clock) disable iff (reset)
      ser_status.done |=> !pack_held_ff && fill_ff == 4'd0)
      else $error("pack still held after its last byte");

   a_no_write_while_reading: assert property (@(posedge clock) disable iff (reset)
      ser_status.rd_en && state_ff == ST_EMIT |-> !wr_en)
      else $error("buffer written during pack readout");

endmodule

>>> test/tb_cd_text_pack_framer.sv
module tb_cd_text_pack_framer;

   import cdtpf_pkg::*;

   class pack_stream_scoreboard;

      logic [7:0]  data_bytes [PACK_DATA_LEN];
      int unsigned fill;
      bit          held;
      bit          held_bin;
      logic [3:0]  held_type;
      logic [7:0]  held_track;
      logic [7:0]  held_seq;
      logic [7:0]  held_bc;
      logic [7:0]  seq_counter;
      logic [15:0] item_pos;
      rsp_type     expected_pack_bytes [$];
      int          errors;

      function new();
         foreach (data_bytes[i]) data_bytes[i] = 8'h00;
         fill        = 0;
         held        = 1'b0;
         held_bin    = 1'b0;
         held_type   = 4'h0;
         held_track  = 8'h00;
         held_seq    = 8'h00;
         held_bc     = 8'h00;
         seq_counter = 8'h00;
         item_pos    = 16'h0000;
         errors      = 0;
      endfunction

      function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
         logic fb;
         for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
         end
         return crc;
      endfunction

      function void emit_held_pack();
         logic [7:0]  pk [PACK_LEN];
         logic [15:0] crc;
         rsp_type     e;
         if (!held) return;
         pk[0] = PACK_TYPE_HI | {4'h0, held_type};
         pk[1] = held_track;
         pk[2] = held_seq;
         pk[3] = held_bc;
         for (int i = 0; i < PACK_DATA_LEN; i++) pk[4 + i] = data_bytes[i];
         crc = 16'h0000;
         for (int i = 0; i < 16; i++) crc = crc16_step(crc, pk[i]);
         crc = ~crc;
         pk[16] = crc[15:8];
         pk[17] = crc[7:0];
         for (int i = 0; i < PACK_LEN; i++) begin
            e.pack_byte  = pk[i];
            e.byte_index = 5'(i);
            e.pack_last  = (i == PACK_LEN - 1);
            expected_pack_bytes.push_back(e);
         end
         held = 1'b0;
         fill = 0;
      endfunction

      function void open_pack(logic [3:0] ptype, logic [7:0] track, logic [2:0] blk,
                              int unsigned cp, bit bin);
         foreach (data_bytes[i]) data_bytes[i] = 8'h00;
         fill        = 0;
         held        = 1'b1;
         held_bin    = bin;
         held_type   = ptype;
         held_track  = track;
         held_seq    = seq_counter;
         seq_counter = seq_counter + 8'd1;
         if (cp > 15) cp = 15;
         held_bc = {1'b0, blk, cp[3:0]};
      endfunction

      function void note_request(req_type r);
         int unsigned pos;
         int unsigned cp;
         logic [7:0]  tb;
         bit          share;
         case (r.cmd)
            CMD_FLUSH: begin
               emit_held_pack();
            end
            CMD_LOAD_SEQ: begin
               seq_counter = r.data_byte;
            end
            CMD_DATA: begin
               if (r.item_start) item_pos = 16'h0000;
               if (r.binary_item) begin
                  if (r.item_start || !held || !held_bin) begin
                     pos = item_pos / PACK_DATA_LEN;
                     cp  = 0;
                     emit_held_pack();
                     if (r.pack_type == TYPE_GENRE) begin
                        tb = 8'h00;
                        if (pos != 0) cp = pos * PACK_DATA_LEN - 2;
                     end else if (r.pack_type == TYPE_TOC1) begin
                        tb = (pos == 0) ? 8'h00 : 8'((pos - 1) * 4 + 1);
                     end else begin
                        tb = 8'(pos);
                     end
                     open_pack(r.pack_type, tb, r.block_number, cp, 1'b1);
                  end
               end else begin
                  share = held && !held_bin &&
                          (!r.item_start || (held_type == r.pack_type &&
                                             held_bc[6:4] == r.block_number));
                  if (!share) begin
                     emit_held_pack();
                     open_pack(r.pack_type, {1'b0, r.track_number}, r.block_number,
                               item_pos, 1'b0);
                  end
               end
               if (fill < PACK_DATA_LEN) data_bytes[fill] = r.data_byte;
               fill++;
               if (item_pos != 16'hffff) item_pos = item_pos + 16'd1;
               if (fill >= PACK_DATA_LEN || (r.binary_item && r.item_end)) emit_held_pack();
            end
            default: begin
            end
         endcase
      endfunction

      function void check_pack_byte(rsp_type got);
         rsp_type exp_byte;
         if (expected_pack_bytes.size() == 0) begin
            $display("%0t: unexpected pack byte: expected none, actual %h index %0d last %b",
                     $time, got.pack_byte, got.byte_index, got.pack_last);
            errors++;
            return;
         end
         exp_byte = expected_pack_bytes.pop_front();
         if (got.pack_byte !== exp_byte.pack_byte) begin
            $display("%0t: pack_byte mismatch: expected %h, actual %h",
                     $time, exp_byte.pack_byte, got.pack_byte);
            errors++;
         end
         if (got.byte_index !== exp_byte.byte_index) begin
            $display("%0t: byte_index mismatch: expected %0d, actual %0d",
                     $time, exp_byte.byte_index, got.byte_index);
            errors++;
         end
         if (got.pack_last !== exp_byte.pack_last) begin
            $display("%0t: pack_last mismatch: expected %b, actual %b",
                     $time, exp_byte.pack_last, got.pack_last);
            errors++;
         end
      endfunction

   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pack_stream_scoreboard board;

   bit         rsp_quiet     = 1'b0;
   int         hold_off_asks = 0;
   int         hold_off_seen = 0;
   int         requests_sent = 0;
   logic [3:0] last_type     = 4'h0;
   logic [2:0] last_block    = 3'h0;

   cd_text_pack_framer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int next_gap();
      if (rsp_quiet) return 0;
      return gap_len();
   endfunction

   function automatic req_type make_req(cmd_type c, logic [7:0] b, logic [3:0] t,
                                        logic [6:0] trk, logic [2:0] blk,
                                        logic bin, logic st, logic en);
      req_type r;
      r.cmd          = c;
      r.data_byte    = b;
      r.pack_type    = t;
      r.track_number = trk;
      r.block_number = blk;
      r.binary_item  = bin;
      r.item_start   = st;
      r.item_end     = en;
      return r;
   endfunction

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic send_request(input req_type r);
      @(negedge clock);
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      if (r.cmd != CMD_NONE) requests_sent++;
      pause_sender(next_gap());
   endtask

   task automatic wait_for_packs();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_pack_bytes.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic send_item(input bit bin, input int len, input logic [3:0] t,
                            input logic [6:0] trk, input logic [2:0] blk);
      for (int i = 0; i < len; i++) begin
         send_request(make_req(CMD_DATA, 8'($urandom), t, trk, blk, bin,
                               i == 0, i == len - 1));
      end
   endtask

   task automatic send_random_item();
      int         kind;
      int         len;
      bit         bin;
      logic [3:0] t;
      logic [2:0] blk;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         bin = ($urandom_range(0, 2) == 0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         if (bin) begin
            case ($urandom_range(0, 2))
               0: t = TYPE_GENRE;
               1: t = TYPE_TOC1;
               default: t = 4'($urandom);
            endcase
            blk = 3'($urandom);
         end else if ($urandom_range(0, 1) == 0) begin
            t   = last_type;
            blk = last_block;
         end else begin
            t   = 4'($urandom);
            blk = 3'($urandom);
         end
         last_type  = t;
         last_block = blk;
         send_item(bin, len, t, 7'($urandom), blk);
      end else if (kind < 80) begin
         send_request(make_req(CMD_FLUSH, 8'($urandom), 4'($urandom), 7'($urandom),
                               3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
      end else if (kind < 85) begin
         send_request(make_req(CMD_LOAD_SEQ, 8'($urandom), 4'($urandom), 7'($urandom),
                               3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
      end else if (kind < 90) begin
         send_request(make_req(CMD_NONE, 8'($urandom), 4'($urandom), 7'($urandom),
                               3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
      end else begin
         send_request(make_req(CMD_DATA, 8'($urandom), 4'($urandom), 7'($urandom),
                               3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
      end
   endtask

   // receiver side stall pattern
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_asks != hold_off_seen) begin
            hold_off_seen++;
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_quiet) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = gap_len();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_pack_byte(rsp_data);
   end

   initial begin
      #48000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      board = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      send_request(make_req(CMD_NONE, 8'ha5, 4'hf, 7'h7f, 3'h7, 1'b1, 1'b1, 1'b1));
      send_request(make_req(CMD_FLUSH, 8'h00, 4'h0, 7'h00, 3'h0, 1'b0, 1'b0, 1'b0));
      send_request(make_req(CMD_LOAD_SEQ, 8'hfe, 4'h0, 7'h00, 3'h0, 1'b0, 1'b0, 1'b0));
      send_request(make_req(CMD_DATA, 8'hff, 4'h0, 7'h7f, 3'h7, 1'b0, 1'b1, 1'b0));
      send_request(make_req(CMD_DATA, 8'h00, 4'h0, 7'h00, 3'h7, 1'b0, 1'b1, 1'b1));
      send_request(make_req(CMD_DATA, 8'h41, 4'h0, 7'h01, 3'h6, 1'b0, 1'b1, 1'b1));
      send_request(make_req(CMD_DATA, 8'h42, 4'hf, 7'h01, 3'h6, 1'b0, 1'b1, 1'b1));
      send_request(make_req(CMD_DATA, 8'h10, TYPE_GENRE, 7'h55, 3'h0, 1'b1, 1'b1, 1'b0));
      send_request(make_req(CMD_DATA, 8'h11, TYPE_GENRE, 7'h00, 3'h0, 1'b1, 1'b0, 1'b1));
      send_request(make_req(CMD_DATA, 8'h20, TYPE_TOC1, 7'h7f, 3'h7, 1'b1, 1'b1, 1'b1));
      send_request(make_req(CMD_DATA, 8'h30, 4'h3, 7'h00, 3'h2, 1'b1, 1'b1, 1'b0));
      send_request(make_req(CMD_DATA, 8'h31, 4'h3, 7'h00, 3'h2, 1'b1, 1'b1, 1'b0));
      send_request(make_req(CMD_DATA, 8'h32, 4'h5, 7'h0c, 3'h1, 1'b0, 1'b0, 1'b0));
      send_request(make_req(CMD_DATA, 8'h33, 4'h9, 7'h0d, 3'h4, 1'b0, 1'b0, 1'b1));
      send_request(make_req(CMD_NONE, 8'h5a, 4'h0, 7'h00, 3'h0, 1'b0, 1'b0, 1'b0));
      send_request(make_req(CMD_DATA, 8'h34, 4'ha, 7'h00, 3'h3, 1'b1, 1'b0, 1'b0));
      send_request(make_req(CMD_DATA, 8'h35, 4'ha, 7'h00, 3'h3, 1'b1, 1'b0, 1'b0));
      send_request(make_req(CMD_FLUSH, 8'hff, 4'hf, 7'h7f, 3'h7, 1'b1, 1'b1, 1'b1));
      send_request(make_req(CMD_FLUSH, 8'h00, 4'h0, 7'h00, 3'h0, 1'b0, 1'b0, 1'b0));
      send_request(make_req(CMD_LOAD_SEQ, 8'h00, 4'h0, 7'h00, 3'h0, 1'b0, 1'b0, 1'b0));
      send_request(make_req(CMD_DATA, 8'h80, 4'h1, 7'h40, 3'h5, 1'b0, 1'b1, 1'b1));
      wait_for_packs();

      // long receiver hold-off with back-to-back input
      rsp_quiet = 1'b1;
      hold_off_asks++;
      send_item(1'b0, 30, 4'h2, 7'h11, 3'h3);
      send_item(1'b1, 20, TYPE_GENRE, 7'h00, 3'h1);
      send_item(1'b1, 26, TYPE_TOC1, 7'h00, 3'h2);
      wait_for_packs();
      rsp_quiet = 1'b0;

      // random
      requests_sent = 0;
      while (requests_sent < 220) begin
         send_random_item();
         if ($urandom_range(0, 99) < 3) wait_for_packs();
         if ($urandom_range(0, 99) < 4) rsp_quiet = !rsp_quiet;
      end
      rsp_quiet = 1'b0;
      wait_for_packs();

      // binary bytes without item start
      rsp_quiet = 1'b1;
      send_request(make_req(CMD_FLUSH, 8'h00, 4'h0, 7'h00, 3'h0, 1'b0, 1'b0, 1'b0));
      send_request(make_req(CMD_DATA, 8'hc3, 4'h3, 7'h00, 3'h4, 1'b1, 1'b0, 1'b1));
      send_request(make_req(CMD_DATA, 8'h3c, TYPE_GENRE, 7'h00, 3'h4, 1'b1, 1'b0, 1'b1));
      send_request(make_req(CMD_DATA, 8'h99, TYPE_TOC1, 7'h00, 3'h4, 1'b1, 1'b0, 1'b1));
      wait_for_packs();

      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
